[hw/rtl/lph_pkg.sv]
// shared types and constants for the linear probing hash table
// used by every module of the block; depends on nothing

`default_nettype none

package lph_pkg;

   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int HASH_W   = 31;

   localparam logic [KEY_W-1:0]   SLOT_FREE       = 32'h0000_0000;
   localparam logic [KEY_W-1:0]   SLOT_TOMB       = 32'hffff_ffff;
   localparam logic [COUNT_W-1:0] MAX_ITEMS_RESET = 5'd15;

   localparam int TABLE_SIZE_DEFAULT  = 31;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT      = 2'd0,
      CMD_PUT_ONCE = 2'd1,
      CMD_GET      = 2'd2,
      CMD_REMOVE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_FULL      = 3'd3,
      ST_RESERVED  = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
      logic                reserved;
   } req_item_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_RED,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_PROBE,
      B_EXEC
   } back_state_type;

endpackage

`default_nettype wire

[hw/rtl/lph_front.sv]
// front end: takes a command, flags reserved keys, computes the home slot
// by a reciprocal multiply; depends on lph_pkg

`default_nettype none

module lph_front #(
   parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [lph_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [lph_pkg::KEY_W-1:0]     req_key,
   input  wire logic [lph_pkg::VALUE_W-1:0]   req_value,
   output      logic                          front_busy,
   input  wire logic                          q_full,
   output      logic                          push,
   output      lph_pkg::req_item_type         push_item,
   output      logic [$clog2(TABLE_SIZE)-1:0] push_home
);

   localparam int SLOT_W = $clog2(TABLE_SIZE);
   localparam int SHIFT  = lph_pkg::HASH_W + SLOT_W;
   localparam int PROD_W = lph_pkg::HASH_W + 32;
   localparam int Q_W    = PROD_W - SHIFT;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / TABLE_SIZE;
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
   localparam logic [SLOT_W:0] SIZE_V = (SLOT_W+1)'(TABLE_SIZE);

   lph_pkg::front_state_type state_ff, state_in;
   lph_pkg::req_item_type    item_ff, item_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [SLOT_W:0]          rem_ff, rem_in;

   logic [Q_W-1:0]           quot;
   logic [lph_pkg::HASH_W-1:0] quot_wide;
   logic [lph_pkg::HASH_W-1:0] quot_n;
   logic [SLOT_W:0]          home_full;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lph_pkg::F_IDLE: begin
            if (accept) state_in = lph_pkg::F_MUL;
         end
         lph_pkg::F_MUL:  state_in = lph_pkg::F_RED;
         lph_pkg::F_RED:  state_in = lph_pkg::F_PUSH;
         lph_pkg::F_PUSH: begin
            if (!q_full) state_in = lph_pkg::F_IDLE;
         end
         default:         state_in = lph_pkg::F_IDLE;
      endcase
   end

   // quotient estimate is low by at most one, so one subtract fixes the remainder
   always_comb begin
      quot      = prod_ff[PROD_W-1:SHIFT];
      quot_wide = lph_pkg::HASH_W'(quot);
      quot_n    = quot_wide * lph_pkg::HASH_W'(TABLE_SIZE);
      home_full = (rem_ff >= SIZE_V) ? (rem_ff - SIZE_V) : rem_ff;
   end

   // outputs and datapath
   always_comb begin
      item_in    = item_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      front_busy = 1'b1;
      push       = 1'b0;
      unique case (state_ff)
         lph_pkg::F_IDLE: begin
            front_busy       = 1'b0;
            item_in.cmd      = lph_pkg::cmd_type'(req_cmd);
            item_in.key      = req_key;
            item_in.value    = req_value;
            item_in.reserved = (req_key == lph_pkg::SLOT_FREE) ||
                               (req_key == lph_pkg::SLOT_TOMB);
         end
         lph_pkg::F_MUL: begin
            prod_in = item_ff.key[lph_pkg::HASH_W-1:0] * RECIP;
         end
         lph_pkg::F_RED: begin
            rem_in = item_ff.key[SLOT_W:0] - quot_n[SLOT_W:0];
         end
         lph_pkg::F_PUSH: begin
            push = !q_full;
         end
         default: begin
            front_busy = 1'b1;
         end
      endcase
   end

   assign push_item = item_ff;
   assign push_home = home_full[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lph_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

endmodule

`default_nettype wire

[hw/rtl/lph_queue.sv]
// short item queue between front and back end
// register based fifo; depends on lph_pkg for its default depth

`default_nettype none

module lph_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = lph_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic              not_empty,
   output      logic [DATA_W-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

[hw/rtl/lph_back.sv]
// back end: slot memories, probe sequencer, command execution and result
// registers; depends on lph_pkg

`default_nettype none

module lph_back #(
   parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lph_pkg::COUNT_W-1:0]   max_items,
   input  wire logic                          q_valid,
   input  wire lph_pkg::req_item_type         q_item,
   input  wire logic [$clog2(TABLE_SIZE)-1:0] q_home,
   output      logic                          q_pop,
   output      logic                          clearing,
   output      logic                          rsp_strobe,
   output      logic [lph_pkg::STATUS_W-1:0]  rsp_status,
   output      logic                          rsp_found,
   output      logic [lph_pkg::VALUE_W-1:0]   rsp_value_out,
   output      logic [lph_pkg::COUNT_W-1:0]   rsp_item_count
);

   localparam int SLOT_W = $clog2(TABLE_SIZE);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

   lph_pkg::back_state_type state_ff, state_in;
   lph_pkg::req_item_type   item_ff, item_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic [SLOT_W-1:0]       n_ff, n_in;
   logic [SLOT_W-1:0]       clr_ff, clr_in;
   logic [SLOT_W-1:0]       ins_slot_ff, ins_slot_in;
   logic                    has_ins_ff, has_ins_in;
   logic                    hit_ff, hit_in;
   logic [lph_pkg::VALUE_W-1:0] hit_val_ff, hit_val_in;
   logic [lph_pkg::COUNT_W-1:0] count_ff, count_in;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   lph_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [lph_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [lph_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [lph_pkg::KEY_W-1:0]   key_mem [TABLE_SIZE];
   logic [lph_pkg::VALUE_W-1:0] val_mem [TABLE_SIZE];
   logic [lph_pkg::KEY_W-1:0]   key_rd_ff;
   logic [lph_pkg::VALUE_W-1:0] val_rd_ff;
   logic [SLOT_W-1:0]           rd_addr;
   logic [SLOT_W-1:0]           wr_addr;
   logic                        key_we, val_we;
   logic [lph_pkg::KEY_W-1:0]   key_wdata;
   logic [lph_pkg::VALUE_W-1:0] val_wdata;

   logic [SLOT_W-1:0] idx_next;
   logic              sk_free, sk_tomb, sk_hit, probe_last;

   assign idx_next   = (idx_ff == LAST_SLOT) ? '0 : idx_ff + SLOT_W'(1);
   assign sk_free    = (key_rd_ff == lph_pkg::SLOT_FREE);
   assign sk_tomb    = (key_rd_ff == lph_pkg::SLOT_TOMB);
   assign sk_hit     = (key_rd_ff == item_ff.key);
   assign probe_last = (n_ff == LAST_SLOT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lph_pkg::B_CLEAR: begin
            if (clr_ff == LAST_SLOT) state_in = lph_pkg::B_IDLE;
         end
         lph_pkg::B_IDLE: begin
            if (q_valid && !q_item.reserved) state_in = lph_pkg::B_PROBE;
         end
         lph_pkg::B_PROBE: begin
            if (sk_hit || sk_free || probe_last) state_in = lph_pkg::B_EXEC;
         end
         lph_pkg::B_EXEC: state_in = lph_pkg::B_IDLE;
         default:         state_in = lph_pkg::B_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      item_in       = item_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      clr_in        = clr_ff;
      ins_slot_in   = ins_slot_ff;
      has_ins_in    = has_ins_ff;
      hit_in        = hit_ff;
      hit_val_in    = hit_val_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      q_pop         = 1'b0;
      clearing      = 1'b0;
      rd_addr       = idx_next;
      wr_addr       = idx_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      key_wdata     = lph_pkg::SLOT_FREE;
      val_wdata     = '0;
      unique case (state_ff)
         lph_pkg::B_CLEAR: begin
            clearing = 1'b1;
            clr_in   = clr_ff + SLOT_W'(1);
            wr_addr  = clr_ff;
            key_we   = 1'b1;
            val_we   = 1'b1;
         end
         lph_pkg::B_IDLE: begin
            rd_addr = q_home;
            if (q_valid) begin
               q_pop      = 1'b1;
               item_in    = q_item;
               idx_in     = q_home;
               n_in       = '0;
               has_ins_in = 1'b0;
               hit_in     = 1'b0;
               if (q_item.reserved) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = lph_pkg::ST_RESERVED;
                  rsp_found_in  = 1'b0;
                  rsp_value_in  = '0;
                  rsp_count_in  = count_ff;
               end
            end
         end
         lph_pkg::B_PROBE: begin
            // slot idx_ff is in the read registers, idx_next is being fetched
            hit_in     = sk_hit;
            hit_val_in = val_rd_ff;
            if ((sk_free || sk_tomb) && !has_ins_ff) begin
               has_ins_in  = 1'b1;
               ins_slot_in = idx_ff;
            end
            if (!(sk_hit || sk_free || probe_last)) begin
               idx_in = idx_next;
               n_in   = n_ff + SLOT_W'(1);
            end
         end
         lph_pkg::B_EXEC: begin
            rsp_strobe_in = 1'b1;
            rsp_found_in  = hit_ff;
            rsp_value_in  = '0;
            rsp_status_in = lph_pkg::ST_OK;
            unique case (item_ff.cmd) inside
               lph_pkg::CMD_PUT, lph_pkg::CMD_PUT_ONCE: begin
                  if (hit_ff) begin
                     if (item_ff.cmd == lph_pkg::CMD_PUT_ONCE) begin
                        rsp_status_in = lph_pkg::ST_EXISTS;
                     end else begin
                        val_we    = 1'b1;
                        val_wdata = item_ff.value;
                     end
                  end else if ((count_ff >= max_items) || !has_ins_ff) begin
                     rsp_status_in = lph_pkg::ST_FULL;
                  end else begin
                     wr_addr   = ins_slot_ff;
                     key_we    = 1'b1;
                     key_wdata = item_ff.key;
                     val_we    = 1'b1;
                     val_wdata = item_ff.value;
                     count_in  = count_ff + lph_pkg::COUNT_W'(1);
                  end
               end
               lph_pkg::CMD_GET: begin
                  if (hit_ff) begin
                     rsp_value_in = hit_val_ff;
                  end else begin
                     rsp_status_in = lph_pkg::ST_NOT_FOUND;
                  end
               end
               lph_pkg::CMD_REMOVE: begin
                  if (hit_ff) begin
                     key_we    = 1'b1;
                     key_wdata = lph_pkg::SLOT_TOMB;
                     val_we    = 1'b1;
                     if (count_ff != '0) count_in = count_ff - lph_pkg::COUNT_W'(1);
                  end else begin
                     rsp_status_in = lph_pkg::ST_NOT_FOUND;
                  end
               end
               default: rsp_status_in = lph_pkg::ST_NOT_FOUND;
            endcase
            rsp_count_in = count_in;
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lph_pkg::B_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      n_ff          <= n_in;
      ins_slot_ff   <= ins_slot_in;
      has_ins_ff    <= has_ins_in;
      hit_ff        <= hit_in;
      hit_val_ff    <= hit_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // slot memories, registered reads
   always_ff @(posedge clock) begin
      if (key_we) key_mem[wr_addr] <= key_wdata;
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem[wr_addr] <= val_wdata;
      val_rd_ff <= val_mem[rd_addr];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_item_count = rsp_count_ff;

`ifndef SYNTH
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lph_pkg::B_CLEAR) |-> !rsp_strobe_ff)
      else $error("result during clearing pass");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lph_pkg::B_PROBE) |-> (n_ff <= LAST_SLOT))
      else $error("probe ran past table size");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_found_ff) |->
      (rsp_status_ff == lph_pkg::ST_OK || rsp_status_ff == lph_pkg::ST_EXISTS))
      else $error("found item with miss status");

   a_value_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff != lph_pkg::ST_OK) |-> (rsp_value_ff == '0))
      else $error("nonzero value on failed command");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (!rsp_strobe_ff || (rsp_count_ff <= TABLE_SIZE)) && (count_ff <= TABLE_SIZE))
      else $error("item count exceeds table size");
`endif

endmodule

`default_nettype wire

[hw/rtl/linear_probe_hash_table.sv]
// top level of the linear probing key/value table
// holds the max_items register; uses lph_pkg, lph_front, lph_queue, lph_back

`default_nettype none

// Usage:
//   Command channel: drive req_cmd, req_key, req_value with start high; the
//   item is taken at a clock edge where start is high and busy is low.
//   Result channel: every item gives one result, shown for a single cycle
//   with rsp_strobe high; the receiver cannot stall it and must take it.
//   Config: csr_we with csr_wdata writes max_items (reset 15). Write it
//   only while the block is idle; the block itself does not enforce this.
//   Flow: the front end takes no new item until its current one is pushed
//   (reciprocal multiply for the home slot, reduction, then a push into a
//   2-entry queue, held while the queue is full); the back end probes slots
//   with one key memory read per cycle, then executes. Reserved keys skip
//   probing and give their result straight from the idle state.
//   Reset: after reset the back end clears all TABLE_SIZE slots, one per
//   cycle; busy stays high during this clearing pass.

module linear_probe_hash_table #(
   parameter int TABLE_SIZE  = lph_pkg::TABLE_SIZE_DEFAULT,
   parameter int QUEUE_DEPTH = lph_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic [lph_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [lph_pkg::KEY_W-1:0]    req_key,
   input  wire logic [lph_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                         csr_we,
   input  wire logic [lph_pkg::COUNT_W-1:0]  csr_wdata,
   output      logic                         rsp_strobe,
   output      logic [lph_pkg::STATUS_W-1:0] rsp_status,
   output      logic                         rsp_found,
   output      logic [lph_pkg::VALUE_W-1:0]  rsp_value_out,
   output      logic [lph_pkg::COUNT_W-1:0]  rsp_item_count
);

   localparam int SLOT_W = $clog2(TABLE_SIZE);
   localparam int ITEM_W = $bits(lph_pkg::req_item_type);
   localparam int DATA_W = ITEM_W + SLOT_W;

   logic [lph_pkg::COUNT_W-1:0] max_items_ff, max_items_in;

   logic                  front_busy;
   logic                  clearing;
   logic                  accept;
   logic                  push;
   lph_pkg::req_item_type push_item;
   logic [SLOT_W-1:0]     push_home;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_valid;
   logic [DATA_W-1:0]     q_head;
   lph_pkg::req_item_type q_item;
   logic [SLOT_W-1:0]     q_home;

   assign busy   = front_busy || clearing;
   assign accept = start && !busy;

   assign max_items_in = csr_we ? csr_wdata : max_items_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_items_ff <= lph_pkg::MAX_ITEMS_RESET;
      end else begin
         max_items_ff <= max_items_in;
      end
   end

   lph_front #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_cmd    (req_cmd),
      .req_key    (req_key),
      .req_value  (req_value),
      .front_busy (front_busy),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item),
      .push_home  (push_home)
   );

   lph_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_item, push_home}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_data (q_head)
   );

   assign q_item = lph_pkg::req_item_type'(q_head[DATA_W-1:SLOT_W]);
   assign q_home = q_head[SLOT_W-1:0];

   lph_back #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .max_items      (max_items_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_home         (q_home),
      .q_pop          (q_pop),
      .clearing       (clearing),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_value_out  (rsp_value_out),
      .rsp_item_count (rsp_item_count)
   );

endmodule

`default_nettype wire
